// ===== hdl/lcgbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgbr_pkg
// Shared types, constants and helpers for the bounded LCG random source.
// ----------------------------------------------------------------------------
package lcgbr_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = $clog2(DataW);

  localparam logic [DataW-1:0] LcgMul = 32'd69069;
  localparam logic [DataW-1:0] LcgInc = 32'd25173;

  // command codes
  localparam logic CmdBit   = 1'b0;
  localparam logic CmdBound = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } lcgbr_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // latch cmd and bound of the accepted request
    logic draw;      // advance the generator and start the remainder
    logic div_step;  // one restoring division step
    logic finish;    // write the result register
  } lcgbr_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic cmd_bound;  // request asks for a bounded value
    logic div_last;   // current division step is the last one
    logic reject;     // drawn value falls in the biased tail
    logic out_free;   // result register can take a new value
  } lcgbr_stat_t;

  // swap the two 16-bit halves of the state
  function automatic logic [DataW-1:0] swap_halves(input logic [DataW-1:0] s);
    swap_halves = {s[DataW/2-1:0], s[DataW-1:DataW/2]};
  endfunction

endpackage

// ===== hdl/lcgbr_if.sv =====
// ----------------------------------------------------------------------------
// lcgbr_req_if / lcgbr_rsp_if
// Valid/ready channels for requests and results of the random source.
// ----------------------------------------------------------------------------
interface lcgbr_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] bound;

  modport source (output valid, output cmd, output bound, input ready);
  modport sink   (input valid, input cmd, input bound, output ready);
endinterface

interface lcgbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== hdl/lcgbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcgbr_ctrl
// Sequencer: accept, draw, iterate the remainder and check bias (bounded only), deliver.
// ----------------------------------------------------------------------------
module lcgbr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  lcgbr_pkg::lcgbr_stat_t stat_i,
  output lcgbr_pkg::lcgbr_ctl_t  ctl_o
);
  import lcgbr_pkg::*;

  lcgbr_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_DRAW;
        end
      end
      ST_DRAW: begin
        ctl_o.draw = 1'b1;
        state_d    = stat_i.cmd_bound ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        ctl_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = stat_i.reject ? ST_DRAW : ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/lcgbr_dp.sv =====
// ----------------------------------------------------------------------------
// lcgbr_dp
// Generator state, restoring remainder unit, bias check and result register.
// ----------------------------------------------------------------------------
module lcgbr_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lcgbr_pkg::DataW-1:0] cfg_wdata_i,
  input  logic                        req_cmd_i,
  input  logic [lcgbr_pkg::DataW-1:0] req_bound_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output logic [lcgbr_pkg::DataW-1:0] rsp_value_o,
  input  lcgbr_pkg::lcgbr_ctl_t       ctl_i,
  output lcgbr_pkg::lcgbr_stat_t      stat_o
);
  import lcgbr_pkg::*;

  logic             lcg_q;
  logic [DataW-1:0] lcg_state_q, lcg_state_d;
  logic             cmd_q;
  logic [DataW-1:0] k_q;
  logic [DataW-1:0] raw_q, raw_d;
  logic [DataW-1:0] dvd_q;
  logic [DataW-1:0] rem_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW:0]   trial;
  logic [DataW-1:0] rem_next;
  logic             out_valid_q;
  logic [DataW-1:0] out_value_q;

  // generator step: multiply then add, registered
  assign lcg_state_d = lcg_state_q * LcgMul + LcgInc;
  assign raw_d       = swap_halves(lcg_state_d);
  assign lcg_q       = 1'b0;

  // generator state: seed at reset and on a seed write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_state_q <= '0;
    end else if (cfg_we_i) begin
      lcg_state_q <= cfg_wdata_i;
    end else if (ctl_i.draw) begin
      lcg_state_q <= lcg_state_d;
    end
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem_q, dvd_q[DataW-1]};
  assign rem_next = (trial >= {1'b0, k_q}) ? DataW'(trial - {1'b0, k_q})
                                           : trial[DataW-1:0];

  // request payload, raw value and remainder unit
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= req_cmd_i;
      k_q   <= (req_bound_i == '0) ? DataW'(1) : req_bound_i;
    end
    if (ctl_i.draw) begin
      raw_q <= raw_d;
      dvd_q <= raw_d;
      rem_q <= '0;
    end else if (ctl_i.div_step) begin
      dvd_q <= {dvd_q[DataW-2:0], lcg_q};
      rem_q <= rem_next;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.draw) begin
      cnt_q <= CntW'(DataW - 1);
    end else if (ctl_i.div_step) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // result register, holds while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      out_value_q <= (cmd_q == CmdBound) ? rem_q : {{(DataW-1){1'b0}}, raw_q[0]};
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_value_o = out_value_q;

  // status back to the sequencer
  assign stat_o.cmd_bound = (cmd_q == CmdBound);
  assign stat_o.div_last  = (cnt_q == '0);
  assign stat_o.reject    = (raw_q - rem_q) > (DataW'(0) - k_q);
  assign stat_o.out_free  = !out_valid_q || rsp_ready_i;

endmodule

// ===== hdl/lcg_bounded_random.sv =====
// ----------------------------------------------------------------------------
// lcg_bounded_random
// Linear congruential random source with random-bit and bounded requests.
// ----------------------------------------------------------------------------
// usage:
//   req carries cmd (0: random bit, 1: value below bound) and bound; a
//   transfer happens when valid and ready are both high. rsp carries value,
//   one result per request, in request order.
//   cfg_we_i / cfg_wdata_i write the seed and reload the generator state at
//   once; write only while no request is in flight.
// sequencing:
//   one request at a time. A bit request goes from its draw to its finish
//   step. A bounded request runs the 32-step restoring remainder unit after
//   each draw, and draws again when the value falls in the biased tail.
// reset:
//   generator state is 0, no result pending, request side ready.
// stall:
//   the result register holds its value until taken; the next request is
//   accepted meanwhile and waits at its finish step for the register.
// ----------------------------------------------------------------------------
module lcg_bounded_random (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lcgbr_pkg::DataW-1:0] cfg_wdata_i,
  lcgbr_req_if.sink                   req_if,
  lcgbr_rsp_if.source                 rsp_if
);
  import lcgbr_pkg::*;

  lcgbr_ctl_t  ctl;
  lcgbr_stat_t stat;

  // sequencer
  lcgbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_if.ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  // datapath
  lcgbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_cmd_i   (req_if.cmd),
    .req_bound_i (req_if.bound),
    .rsp_valid_o (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_value_o (rsp_if.value),
    .ctl_i       (ctl),
    .stat_o      (stat)
  );

  // an accepted request starts with a draw
  a_accept_draw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_if.valid && req_if.ready) |=> ctl.draw)
    else $error("accepted request not followed by a draw");

  // a finished item shows up on the result channel
  a_finish_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.finish |=> rsp_if.valid)
    else $error("finished result not presented");

  // a random bit result has no upper bits set
  a_bit_narrow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.finish && !stat.cmd_bound) |=> (rsp_if.value[DataW-1:1] == '0))
    else $error("random bit result wider than one bit");

  // no two datapath commands (load, draw, division step, finish) coincide
  a_cmd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.load, ctl.draw, ctl.div_step, ctl.finish}))
    else $error("datapath commands overlap");

endmodule
